>>> hdl/mcpt_pkg.sv
// ----------------------------------------------------------------------------
// mcpt_pkg
// Shared types, constants and command/status structs of the MIDI clock
// position and tempo tracker.
// ----------------------------------------------------------------------------
package mcpt_pkg;

  localparam int PORTS     = 4;
  localparam int SAMPLES   = 7;
  localparam int PTR_W     = $clog2(SAMPLES);
  localparam int RING_N    = PORTS * SAMPLES;
  localparam int RING_AW   = $clog2(RING_N);
  localparam int WALK_END  = SAMPLES + 1;
  localparam int WCNT_W    = $clog2(WALK_END + 1);
  localparam int WEIGHT_W  = 7;
  localparam int ACC_W     = 32 + WEIGHT_W + 4;

  localparam logic [2:0] TICK_ARMED = 3'd7;
  localparam logic [2:0] TICK_LAST  = 3'd5;

  localparam logic [7:0] ST_CLOCK = 8'hf8;
  localparam logic [7:0] ST_START = 8'hfa;
  localparam logic [7:0] ST_SPP   = 8'hf2;

  localparam logic [3:0] CIN_SPP     = 4'd3;
  localparam logic [3:0] CIN_SINGLE  = 4'd5;
  localparam logic [3:0] CIN_BYTE    = 4'd15;

  localparam logic [1:0] REG_MONITOR = 2'd0;
  localparam logic [1:0] REG_TEMPO   = 2'd1;
  localparam logic [1:0] REG_MAXTICK = 2'd2;

  typedef logic [WEIGHT_W-1:0] weight_arr_t [SAMPLES-1];

  function automatic weight_arr_t gen_weights();
    weight_arr_t w;
    int          v;
    v = 100;
    for (int i = 0; i < SAMPLES - 1; i++) begin
      w[i] = WEIGHT_W'(v);
      v    = (v * 100) / 110;
    end
    return w;
  endfunction

  function automatic int weight_sum();
    int v;
    int s;
    v = 100;
    s = 0;
    for (int i = 0; i < SAMPLES - 1; i++) begin
      s = s + v;
      v = (v * 100) / 110;
    end
    return s;
  endfunction

  localparam weight_arr_t WEIGHTS = gen_weights();
  localparam int          NUM     = 25000 * weight_sum();
  localparam int          NUM_W   = $clog2(NUM + 1);
  localparam int          DCNT_W  = $clog2(NUM_W + 1);

  typedef struct packed {
    logic capture;
    logic exec;
    logic walk_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic report;
    logic walk_done;
    logic div_done;
    logic out_free;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

endpackage

>>> hdl/mcpt_if.sv
// ----------------------------------------------------------------------------
// mcpt channel interfaces
// Packet input channel and report output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  port_slot;
  logic        port_tracked;
  logic [3:0]  packet_type;
  logic [7:0]  status_byte;
  logic [6:0]  data_low;
  logic [6:0]  data_high;
  logic [31:0] arrival_ms;
  modport source (output valid, port_slot, port_tracked, packet_type, status_byte,
                  data_low, data_high, arrival_ms, input ready);
  modport sink   (input valid, port_slot, port_tracked, packet_type, status_byte,
                  data_low, data_high, arrival_ms, output ready);
endinterface

interface mcpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  report_port;
  logic [31:0] measure_count;
  logic [1:0]  beat_in_measure;
  logic [1:0]  step_in_beat;
  logic        tempo_valid;
  logic [15:0] bpm_tenths;
  modport source (output valid, report_port, measure_count, beat_in_measure,
                  step_in_beat, tempo_valid, bpm_tenths, input ready);
  modport sink   (input valid, report_port, measure_count, beat_in_measure,
                  step_in_beat, tempo_valid, bpm_tenths, output ready);
endinterface

>>> hdl/midi_clock_position_tempo_tracker.sv
// ----------------------------------------------------------------------------
// midi_clock_position_tempo_tracker
// Per-port MIDI clock song position and weighted tempo tracker.
//
// in_ch takes one USB-MIDI packet per transaction with its ms timestamp.
// out_ch gives one report per sixteenth boundary when tempo reports are on:
// port, measure, beat, step, tempo valid flag and tempo in tenths of BPM.
// The cfg port writes monitor enable, tempo enable and the tick limit.
// A packet with no report passes a capture step and an update step. A report
// adds a ring walk, a restoring division of one quotient bit per cycle and
// an output load step.
// One packet is in work at a time; the next packet is taken while a report
// waits in the output register. If the receiver stalls, a finished report
// holds the block in its load step until the register frees.
// Reset clears the position of every port, arms the tick counters, zeroes
// the timestamp ring and the configuration takes its reset values.
// ----------------------------------------------------------------------------
module midi_clock_position_tempo_tracker
  import mcpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mcpt_in_if.sink     in_ch,
  mcpt_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t    cmd;
  status_t st;

  mcpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mcpt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_slot_i    (in_ch.port_slot),
    .in_tracked_i (in_ch.port_tracked),
    .in_type_i    (in_ch.packet_type),
    .in_status_i  (in_ch.status_byte),
    .in_lo_i      (in_ch.data_low),
    .in_hi_i      (in_ch.data_high),
    .in_time_i    (in_ch.arrival_ms),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_port_o   (out_ch.report_port),
    .out_meas_o   (out_ch.measure_count),
    .out_beat_o   (out_ch.beat_in_measure),
    .out_step_o   (out_ch.step_in_beat),
    .out_tvalid_o (out_ch.tempo_valid),
    .out_bpm_o    (out_ch.bpm_tenths)
  );

endmodule

>>> hdl/mcpt_ctrl.sv
// ----------------------------------------------------------------------------
// mcpt_ctrl
// Controller: sequences capture, update, ring walk, division and output load.
// ----------------------------------------------------------------------------
module mcpt_ctrl
  import mcpt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = st_i.report ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        if (st_i.walk_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_DIV: begin
        if (st_i.div_done) state_d = S_DONE;
        else cmd_o.div_step = 1'b1;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

>>> hdl/mcpt_dp.sv
// ----------------------------------------------------------------------------
// mcpt_dp
// Datapath: configuration, per-port position, timestamp ring, weighted sum,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module mcpt_dp
  import mcpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output status_t     st_o,
  input  logic [1:0]  in_slot_i,
  input  logic        in_tracked_i,
  input  logic [3:0]  in_type_i,
  input  logic [7:0]  in_status_i,
  input  logic [6:0]  in_lo_i,
  input  logic [6:0]  in_hi_i,
  input  logic [31:0] in_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_port_o,
  output logic [31:0] out_meas_o,
  output logic [1:0]  out_beat_o,
  output logic [1:0]  out_step_o,
  output logic        out_tvalid_o,
  output logic [15:0] out_bpm_o
);

  logic        mon_en_q, tempo_en_q;
  logic [15:0] max_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_en_q   <= 1'b0;
      tempo_en_q <= 1'b0;
      max_tick_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MONITOR: mon_en_q   <= cfg_data_i[0];
        REG_TEMPO:   tempo_en_q <= cfg_data_i[0];
        REG_MAXTICK: max_tick_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured packet
  logic [1:0]  slot_q;
  logic        tracked_q;
  logic [3:0]  type_q;
  logic [7:0]  status_q;
  logic [6:0]  lo_q, hi_q;
  logic [31:0] time_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q    <= in_slot_i;
      tracked_q <= in_tracked_i;
      type_q    <= in_type_i;
      status_q  <= in_status_i;
      lo_q      <= in_lo_i;
      hi_q      <= in_hi_i;
      time_q    <= in_time_i;
    end
  end

  // per-port position
  logic [2:0]       tick_q [PORTS];
  logic [1:0]       step_q [PORTS];
  logic [1:0]       beat_q [PORTS];
  logic [31:0]      meas_q [PORTS];
  logic [PTR_W-1:0] rwi_q  [PORTS];
  logic [31:0]      ring_q [RING_N];

  logic             act, single, is_spp, is_start, is_clk;
  logic [13:0]      spp;
  logic [2:0]       nt;
  logic [1:0]       ns, nb;
  logic [31:0]      nm;
  logic [PTR_W-1:0] w_cur, w_nxt;
  logic [RING_AW-1:0] w_addr;

  always_comb begin
    act      = mon_en_q && tracked_q && (int'(slot_q) < PORTS);
    single   = (type_q == CIN_SINGLE) || (type_q == CIN_BYTE);
    is_spp   = (type_q == CIN_SPP) && (status_q == ST_SPP);
    is_start = single && (status_q == ST_START);
    is_clk   = single && (status_q == ST_CLOCK);
    spp      = {hi_q, lo_q};
    nt       = tick_q[slot_q];
    ns       = step_q[slot_q];
    nb       = beat_q[slot_q];
    nm       = meas_q[slot_q];
    if (is_spp) begin
      nt = TICK_ARMED;
      ns = spp[1:0];
      nb = spp[3:2];
      nm = {22'd0, spp[13:4]};
    end else if (is_start) begin
      nt = TICK_ARMED;
      ns = 2'd0;
      nb = 2'd0;
      nm = '0;
    end else if (is_clk) begin
      if (tick_q[slot_q] == TICK_ARMED) begin
        nt = 3'd0;
      end else if (tick_q[slot_q] >= TICK_LAST) begin
        nt = 3'd0;
        ns = step_q[slot_q] + 2'd1;
        if (step_q[slot_q] == 2'd3) begin
          nb = beat_q[slot_q] + 2'd1;
          if (beat_q[slot_q] == 2'd3) nm = meas_q[slot_q] + 32'd1;
        end
      end else begin
        nt = tick_q[slot_q] + 3'd1;
      end
    end
    w_cur  = rwi_q[slot_q];
    w_nxt  = (int'(w_cur) == SAMPLES - 1) ? '0 : w_cur + PTR_W'(1);
    w_addr = RING_AW'(RING_AW'(slot_q) * RING_AW'(SAMPLES)) + RING_AW'(w_cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORTS; p++) begin
        tick_q[p] <= TICK_ARMED;
        step_q[p] <= '0;
        beat_q[p] <= '0;
        meas_q[p] <= '0;
        rwi_q[p]  <= '0;
      end
      for (int r = 0; r < RING_N; r++) ring_q[r] <= '0;
    end else if (cmd_i.exec && act) begin
      tick_q[slot_q] <= nt;
      step_q[slot_q] <= ns;
      beat_q[slot_q] <= nb;
      meas_q[slot_q] <= nm;
      if (is_clk) begin
        rwi_q[slot_q]  <= w_nxt;
        ring_q[w_addr] <= time_q;
      end
    end
  end

  // result fields held for the report
  logic [1:0]  res_port_q, res_step_q, res_beat_q;
  logic [31:0] res_meas_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_port_q <= slot_q;
      res_step_q <= ns;
      res_beat_q <= nb;
      res_meas_q <= nm;
    end
  end

  // ring walk, oldest first
  logic [WCNT_W-1:0]  wcnt_q;
  logic [PTR_W-1:0]   ptr_q;
  logic [31:0]        rd_q, prev_q, delta;
  logic [ACC_W-1:0]   acc_q;
  logic               bad_q;
  logic [RING_AW-1:0] r_addr;
  logic [WEIGHT_W-1:0] wt;

  always_comb begin
    r_addr = RING_AW'(RING_AW'(res_port_q) * RING_AW'(SAMPLES)) + RING_AW'(ptr_q);
    delta  = rd_q - prev_q;
    wt     = (wcnt_q >= WCNT_W'(2)) ? WEIGHTS[PTR_W'(wcnt_q - WCNT_W'(2))] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
    end else if (cmd_i.exec) begin
      wcnt_q <= '0;
    end else if (cmd_i.walk_step) begin
      wcnt_q <= wcnt_q + WCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ptr_q <= w_nxt;
      acc_q <= '0;
      bad_q <= 1'b0;
    end else if (cmd_i.walk_step) begin
      if (int'(wcnt_q) < SAMPLES) begin
        rd_q  <= ring_q[r_addr];
        ptr_q <= (int'(ptr_q) == SAMPLES - 1) ? '0 : ptr_q + PTR_W'(1);
      end
      if (wcnt_q >= WCNT_W'(1)) prev_q <= rd_q;
      if (wcnt_q >= WCNT_W'(2)) begin
        acc_q <= acc_q + ACC_W'(delta * wt);
        if (delta >= {16'd0, max_tick_q}) bad_q <= 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DCNT_W-1:0] dcnt_q;
  logic [NUM_W-1:0]  num_q, quo_q;
  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W:0]    trial;
  logic              ge;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = ACC_W'(trial) >= acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DCNT_W'(NUM_W);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= NUM_W'(NUM);
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? NUM_W'(ACC_W'(trial) - acc_q) : NUM_W'(trial);
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  // output register
  logic        out_valid_q;
  logic        tvalid;
  logic [15:0] bpm;

  always_comb begin
    tvalid = !bad_q && (acc_q != '0);
    if (!tvalid) bpm = '0;
    else if (quo_q > NUM_W'(16'hffff)) bpm = 16'hffff;
    else bpm = 16'(quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_port_o   <= res_port_q;
      out_meas_o   <= res_meas_q;
      out_beat_o   <= res_beat_q;
      out_step_o   <= res_step_q;
      out_tvalid_o <= tvalid;
      out_bpm_o    <= bpm;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign st_o.report      = act && is_clk && (nt == 3'd0) && tempo_en_q;
  assign st_o.walk_done   = (int'(wcnt_q) == WALK_END);
  assign st_o.div_done    = (dcnt_q == '0);
  assign st_o.out_free    = !out_valid_q || out_ready_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output overwritten");
  a_bpm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_tvalid_o) |-> (out_bpm_o == 16'd0))
    else $error("bpm nonzero on invalid tempo");
  a_walk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wcnt_q) <= WALK_END)
    else $error("walk counter overrun");

endmodule

>>> sim/mcpt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcpt_checker
// Watches the packet and report channels of the clock position tracker,
// predicts each report from accepted packets and compares field by field.
// ----------------------------------------------------------------------------
module mcpt_checker
  import mcpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mcpt_in_if.sink     in_mon,
  mcpt_out_if.sink    out_mon,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  port;
    logic [31:0] measure;
    logic [1:0]  beat;
    logic [1:0]  step;
    logic        tvalid;
    logic [15:0] bpm;
  } report_t;

  report_t     report_q[$];
  logic        mon_en, tempo_en;
  logic [15:0] tick_limit;
  logic [2:0]  tick_cnt [PORTS];
  logic [1:0]  step_cnt [PORTS];
  logic [1:0]  beat_cnt [PORTS];
  logic [31:0] meas_cnt [PORTS];
  logic [31:0] stamps [PORTS][SAMPLES];
  logic [2:0]  wr_ptr [PORTS];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = report_q.size();

  function automatic void tempo_of(input int s, output logic ok_o, output logic [15:0] bpm_o);
    int          p;
    logic [31:0] prev, d;
    logic [63:0] acc, wsum, q;
    int          w;
    logic        ok;
    p = wr_ptr[s];
    prev = stamps[s][p];
    acc = 0; wsum = 0; w = 100; ok = 1;
    for (int i = 0; i < SAMPLES - 1; i++) begin
      p = (p + 1 >= SAMPLES) ? 0 : p + 1;
      d = stamps[s][p] - prev;
      if (d >= {16'd0, tick_limit}) ok = 0;
      acc += 64'(w) * d;
      wsum += 64'(w);
      w = (w * 100) / 110;
      prev = stamps[s][p];
    end
    if (!ok || acc == 0) begin
      ok_o = 0; bpm_o = 0;
    end else begin
      q = (64'd25000 * wsum) / acc;
      ok_o = 1; bpm_o = (q > 65535) ? 16'hffff : q[15:0];
    end
  endfunction

  task automatic track_packet();
    int          s;
    logic        single;
    logic [13:0] sp;
    report_t     r;
    s = in_mon.port_slot;
    single = (in_mon.packet_type == CIN_SINGLE) || (in_mon.packet_type == CIN_BYTE);
    if (!mon_en || !in_mon.port_tracked) return;
    if (in_mon.packet_type == CIN_SPP && in_mon.status_byte == ST_SPP) begin
      sp = {in_mon.data_high, in_mon.data_low};
      step_cnt[s] = sp[1:0]; beat_cnt[s] = sp[3:2]; meas_cnt[s] = 32'(sp[13:4]);
      tick_cnt[s] = TICK_ARMED;
      return;
    end
    if (single && in_mon.status_byte == ST_START) begin
      step_cnt[s] = 0; beat_cnt[s] = 0; meas_cnt[s] = 0; tick_cnt[s] = TICK_ARMED;
      return;
    end
    if (!(single && in_mon.status_byte == ST_CLOCK)) return;
    if (tick_cnt[s] == TICK_ARMED) tick_cnt[s] = 0;
    else if (tick_cnt[s] >= TICK_LAST) begin
      tick_cnt[s] = 0;
      if (step_cnt[s] == 3) begin
        step_cnt[s] = 0;
        if (beat_cnt[s] == 3) begin
          beat_cnt[s] = 0; meas_cnt[s] = meas_cnt[s] + 1;
        end else beat_cnt[s]++;
      end else step_cnt[s]++;
    end else tick_cnt[s]++;
    stamps[s][wr_ptr[s]] = in_mon.arrival_ms;
    wr_ptr[s] = (wr_ptr[s] + 1 >= SAMPLES) ? 0 : wr_ptr[s] + 1;
    if (tick_cnt[s] != 0 || !tempo_en) return;
    r.port = s[1:0]; r.measure = meas_cnt[s]; r.beat = beat_cnt[s]; r.step = step_cnt[s];
    tempo_of(s, r.tvalid, r.bpm);
    report_q.push_back(r);
  endtask

  task automatic compare_report();
    report_t e, a;
    a = '{out_mon.report_port, out_mon.measure_count, out_mon.beat_in_measure,
          out_mon.step_in_beat, out_mon.tempo_valid, out_mon.bpm_tenths};
    if (report_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected report %p", a);
      return;
    end
    e = report_q.pop_front();
    if (a !== e) begin
      fails++;
      if (fails <= 10) $display("report mismatch: expected %p actual %p", e, a);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_en <= 0; tempo_en <= 0; tick_limit <= 16'd1000; fails <= 0;
      for (int s = 0; s < PORTS; s++) begin
        tick_cnt[s] <= TICK_ARMED; step_cnt[s] <= 0; beat_cnt[s] <= 0;
        meas_cnt[s] <= 0; wr_ptr[s] <= 0;
        for (int k = 0; k < SAMPLES; k++) stamps[s][k] <= 0;
      end
    end else begin
      if (out_mon.valid && out_mon.ready) compare_report();
      if (in_mon.valid && in_mon.ready) track_packet();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MONITOR: mon_en <= cfg_data_i[0];
          REG_TEMPO: tempo_en <= cfg_data_i[0];
          REG_MAXTICK: tick_limit <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives MIDI clock, start, song position and noise packets into the tracker
// under several settings with random gaps and stalls; a checker predicts
// and compares every report.
// ----------------------------------------------------------------------------
module testbench;
  import mcpt_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = 0;
  logic [15:0] cfg_data_i = 0;
  logic        hold_off = 0;
  int          ph_now = -1;
  int          fail_count, pending;
  logic [31:0] now_ms [4];

  mcpt_in_if  in_ch ();
  mcpt_out_if out_ch ();

  midi_clock_position_tempo_tracker u_top (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  mcpt_checker u_checker (
    .clk_i, .rst_ni, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0; in_ch.port_slot = 0; in_ch.port_tracked = 0; in_ch.packet_type = 0;
    in_ch.status_byte = 0; in_ch.data_low = 0; in_ch.data_high = 0; in_ch.arrival_ms = 0;
    out_ch.ready = 0;
  end

  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

  // long receiver stall, timed in cycles
  initial begin
    wait (ph_now == 1);
    hold_off <= 1;
    repeat (400) @(posedge clk_i);
    hold_off <= 0;
  end

  always @(posedge clk_i) begin
    if (hold_off) out_ch.ready <= 0;
    else if (($urandom_range(0, 63) < 3)) out_ch.ready <= 1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send(input logic [1:0] s, input logic trk, input logic [3:0] ty,
                      input logic [7:0] st, input logic [6:0] lo, input logic [6:0] hi,
                      input logic [31:0] ms);
    in_ch.valid <= 1; in_ch.port_slot <= s; in_ch.port_tracked <= trk;
    in_ch.packet_type <= ty; in_ch.status_byte <= st; in_ch.data_low <= lo;
    in_ch.data_high <= hi; in_ch.arrival_ms <= ms;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic clock_tick(input logic [1:0] s, input int gap_max);
    now_ms[s] = now_ms[s] + $urandom_range(0, gap_max);
    send(s, 1, ($urandom_range(0, 1) ? CIN_SINGLE : CIN_BYTE), ST_CLOCK,
         7'($urandom), 7'($urandom), now_ms[s]);
  endtask

  // wait until no packet is in work before writing
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    in_ch.valid <= 0;
    do @(posedge clk_i); while (!in_ch.ready);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_packet(input int gap_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) clock_tick(2'($urandom), gap_max);
    else if (r < 80)
      send(2'($urandom), 1, CIN_SPP, ST_SPP, 7'($urandom), 7'($urandom), $urandom);
    else if (r < 85) send(2'($urandom), 1, CIN_SINGLE, ST_START, 0, 0, $urandom);
    else send(2'($urandom), 1'($urandom), 4'($urandom), 8'($urandom),
              7'($urandom), 7'($urandom), $urandom);
  endtask

  initial begin
    for (int s = 0; s < 4; s++) now_ms[s] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // disabled monitor: ignored
    send(0, 1, CIN_SINGLE, ST_CLOCK, 0, 0, 0);
    write_reg(REG_MONITOR, 1);
    write_reg(REG_TEMPO, 1);
    write_reg(2'd3, 16'hffff);
    // directed
    send(1, 1, CIN_SPP, ST_SPP, 7'h7f, 7'h7f, 32'hffff_ffff);
    for (int i = 0; i < 7; i++) clock_tick(1, 30);
    send(2, 1, CIN_SPP, ST_SPP, 7'h55, 7'h2a, 0);
    send(2, 0, CIN_SINGLE, ST_CLOCK, 0, 0, 0);
    send(3, 1, CIN_BYTE, ST_START, 0, 0, 0);
    for (int i = 0; i < 7; i++) send(3, 1, CIN_BYTE, ST_CLOCK, 0, 0, 32'd5);
    send(0, 1, CIN_SPP, ST_CLOCK, 0, 0, 0);
    send(0, 1, CIN_SINGLE, ST_SPP, 0, 0, 0);
    send(0, 1, 4'd4, ST_START, 0, 0, 0);
    for (int i = 0; i < 6; i++) send(0, 1, CIN_SINGLE, ST_CLOCK, 0, 0, 32'hffff_fff0 + i*9);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      int lim, gmax;
      case (ph)
        0: lim = 1;
        1: lim = 65535;
        2: lim = 0;
        default: lim = $urandom_range(5, 400);
      endcase
      gmax = (ph == 3) ? 3 : 40;
      write_reg(REG_MAXTICK, 16'(lim));
      write_reg(REG_TEMPO, (ph == 4) ? 0 : 1);
      write_reg(REG_MONITOR, (ph == 5) ? 0 : 1);
      ph_now = ph;
      for (int n = 0; n < 135; n++) begin
        random_packet(gmax);
        if ($urandom_range(0, 7) == 0) pause_sender();
      end
      write_reg(REG_MONITOR, 1);
      drain();
    end
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
